// ----- hw/rtl/fvc_pkg.sv -----
// ----------------------------------------------------------------------------
// Frustum classifier package
// Shared widths, operation and result codes, and the per-plane flag bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fvc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int NUM_REGS    = 6;
  localparam int COORD_WIDTH = 16;
  localparam int NORM_W      = 16;
  localparam int NORM_FRAC   = 14;
  localparam int PLANE_W     = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int RADIUS_W    = COORD_WIDTH - 1;
  localparam int PROD_W      = NORM_W + COORD_WIDTH;
  localparam int DIST_W      = NORM_W + ((COORD_WIDTH > NORM_W) ? COORD_WIDTH : NORM_W) + 3;

  localparam logic [NUM_REGS-1:0] ACTIVE_MASK = NUM_REGS'((1 << PLANE_COUNT) - 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]      norm_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [DIST_W-1:0]      dist_t;

  localparam logic [1:0] OP_POINT  = 2'd0;
  localparam logic [1:0] OP_SPHERE = 2'd1;
  localparam logic [1:0] OP_BOX    = 2'd2;

  localparam logic [1:0] VIS_INSIDE  = 2'd0;
  localparam logic [1:0] VIS_CROSS   = 2'd1;
  localparam logic [1:0] VIS_OUTSIDE = 2'd2;

  typedef struct packed {
    logic pt_out;
    logic sph_out;
    logic sph_cross;
    logic box_out;
    logic box_cross;
  } plane_flags_t;

endpackage

// ----- hw/rtl/fvc_plane_unit.sv -----
// ----------------------------------------------------------------------------
// Frustum classifier plane unit
// Registers the normal-by-coordinate products for one plane, then sums them
// with the scaled offset and compares against zero and the sphere radius.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvc_plane_unit (
  input  logic                         clk,
  input  logic                         en,
  input  logic [fvc_pkg::PLANE_W-1:0]  plane,
  input  fvc_pkg::coord_t              p [3],
  input  fvc_pkg::coord_t              q [3],
  input  fvc_pkg::dist_t               rs,
  output fvc_pkg::plane_flags_t        flags
);

  fvc_pkg::norm_t n [3];
  fvc_pkg::norm_t off;
  fvc_pkg::prod_t prod_p [3];
  fvc_pkg::prod_t prod_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      n[a] = fvc_pkg::norm_t'(plane[a*fvc_pkg::NORM_W +: fvc_pkg::NORM_W]);
    end
    off = fvc_pkg::norm_t'(plane[fvc_pkg::PLANE_W-1 -: fvc_pkg::NORM_W]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        prod_p[a] <= fvc_pkg::prod_t'(n[a]) * fvc_pkg::prod_t'(p[a]);
        prod_q[a] <= fvc_pkg::prod_t'(n[a]) * fvc_pkg::prod_t'(q[a]);
      end
    end
  end

  // Per axis, the larger product belongs to the far corner, the smaller to the near one
  always_comb begin
    fvc_pkg::dist_t d;
    fvc_pkg::dist_t dmax;
    fvc_pkg::dist_t dmin;
    fvc_pkg::dist_t off_s;
    off_s = fvc_pkg::dist_t'(off) <<< fvc_pkg::NORM_FRAC;
    d     = off_s;
    dmax  = off_s;
    dmin  = off_s;
    for (int a = 0; a < 3; a++) begin
      d = d + fvc_pkg::dist_t'(prod_p[a]);
      if (prod_p[a] > prod_q[a]) begin
        dmax = dmax + fvc_pkg::dist_t'(prod_p[a]);
        dmin = dmin + fvc_pkg::dist_t'(prod_q[a]);
      end else begin
        dmax = dmax + fvc_pkg::dist_t'(prod_q[a]);
        dmin = dmin + fvc_pkg::dist_t'(prod_p[a]);
      end
    end
    flags.pt_out    = (d < 0);
    flags.sph_out   = (d < -rs);
    flags.sph_cross = (d < rs);
    flags.box_out   = (dmax < 0);
    flags.box_cross = (dmin < 0);
  end

endmodule

// ----- hw/rtl/frustum_volume_classifier_3d.sv -----
// ----------------------------------------------------------------------------
// Six-plane frustum classifier
// Classifies points sets, spheres and boxes as inside, intersecting or outside.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the input, product and result registers in turn.
// Throughput: one item per cycle unless m_axis_tready back-pressure stalls the
//   pipeline; each register takes one item a cycle, with all six planes in parallel.
// Reset: rst clears all pipeline valids, the plane registers to zero and the
//   point-set state to all-out ones and any-out zeros.
`timescale 1ns / 1ps

module frustum_volume_classifier_3d (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // px[15:0], py[31:16], pz[47:32], qx[63:48], qy[79:64], qz[95:80],
  // radius[110:96], zero[111]
  input  logic [111:0]                     s_axis_tdata,
  input  logic                             s_axis_tlast,   // last_point
  input  logic [1:0]                       s_axis_tuser,   // op
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // visibility[1:0], zero[7:2]
  output logic [7:0]                       m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [fvc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fvc_pkg::PLANE_W-1:0]      cfg_data
);

  localparam int CW = fvc_pkg::COORD_WIDTH;
  localparam int NR = fvc_pkg::NUM_REGS;

  logic [fvc_pkg::PLANE_W-1:0] plane [NR];

  logic                        s1_valid;
  logic [1:0]                  s1_op;
  logic                        s1_last;
  fvc_pkg::coord_t             s1_p [3];
  fvc_pkg::coord_t             s1_q [3];
  logic [fvc_pkg::RADIUS_W-1:0] s1_radius;

  logic                        s2_valid;
  logic [1:0]                  s2_op;
  logic                        s2_last;
  logic [fvc_pkg::RADIUS_W-1:0] s2_radius;

  logic                        out_valid;
  logic [1:0]                  out_vis;

  logic [NR-1:0]               all_out;
  logic [NR-1:0]               any_out;
  logic [NR-1:0]               all_out_next;
  logic [NR-1:0]               any_out_next;

  logic                        out_ready;
  logic                        s2_ready;
  logic                        s1_ready;
  logic                        s_fire;
  logic                        s2_fire;
  logic                        s2_emit;
  logic [1:0]                  s2_vis;

  fvc_pkg::dist_t              rs;
  fvc_pkg::plane_flags_t       flags [NR];
  logic [NR-1:0]               pt_vec;
  logic [NR-1:0]               sph_out_vec;
  logic [NR-1:0]               sph_cross_vec;
  logic [NR-1:0]               box_out_vec;
  logic [NR-1:0]               box_cross_vec;

  assign out_ready     = !out_valid || m_axis_tready;
  assign s2_ready      = !s2_valid || out_ready;
  assign s1_ready      = !s1_valid || s2_ready;
  assign s_axis_tready = s1_ready;
  assign s_fire        = s_axis_tvalid && s1_ready;
  assign s2_fire       = s2_valid && out_ready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_vis};

  assign rs = fvc_pkg::dist_t'(s2_radius) <<< fvc_pkg::NORM_FRAC;

  genvar gi;
  generate
    for (gi = 0; gi < NR; gi++) begin : g_plane
      if (gi < fvc_pkg::PLANE_COUNT) begin : g_active
        fvc_plane_unit u_plane (
          .clk   (clk),
          .en    (s2_ready),
          .plane (plane[gi]),
          .p     (s1_p),
          .q     (s1_q),
          .rs    (rs),
          .flags (flags[gi])
        );
      end else begin : g_idle
        assign flags[gi] = '0;
      end
      assign pt_vec[gi]        = flags[gi].pt_out;
      assign sph_out_vec[gi]   = flags[gi].sph_out;
      assign sph_cross_vec[gi] = flags[gi].sph_cross;
      assign box_out_vec[gi]   = flags[gi].box_out;
      assign box_cross_vec[gi] = flags[gi].box_cross;
    end
  endgenerate

  // Classify the item in the product stage and fold points into the set state
  always_comb begin
    logic [NR-1:0] all_upd;
    logic [NR-1:0] any_upd;
    all_upd      = all_out & pt_vec & fvc_pkg::ACTIVE_MASK;
    any_upd      = any_out | (pt_vec & fvc_pkg::ACTIVE_MASK);
    all_out_next = all_out;
    any_out_next = any_out;
    s2_emit      = 1'b0;
    s2_vis       = fvc_pkg::VIS_INSIDE;
    unique case (s2_op)
      fvc_pkg::OP_POINT: begin
        s2_emit = s2_last;
        if ((all_upd & fvc_pkg::ACTIVE_MASK) != '0) begin
          s2_vis = fvc_pkg::VIS_OUTSIDE;
        end else if ((any_upd & fvc_pkg::ACTIVE_MASK) != '0) begin
          s2_vis = fvc_pkg::VIS_CROSS;
        end
        if (s2_last) begin
          all_out_next = '1;
          any_out_next = '0;
        end else begin
          all_out_next = all_upd;
          any_out_next = any_upd;
        end
      end
      fvc_pkg::OP_SPHERE: begin
        s2_emit = 1'b1;
        if ((sph_out_vec & fvc_pkg::ACTIVE_MASK) != '0) begin
          s2_vis = fvc_pkg::VIS_OUTSIDE;
        end else if ((sph_cross_vec & fvc_pkg::ACTIVE_MASK) != '0) begin
          s2_vis = fvc_pkg::VIS_CROSS;
        end
      end
      fvc_pkg::OP_BOX: begin
        s2_emit = 1'b1;
        if ((box_out_vec & fvc_pkg::ACTIVE_MASK) != '0) begin
          s2_vis = fvc_pkg::VIS_OUTSIDE;
        end else if ((box_cross_vec & fvc_pkg::ACTIVE_MASK) != '0) begin
          s2_vis = fvc_pkg::VIS_CROSS;
        end
      end
      default: begin
        s2_emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      all_out   <= '1;
      any_out   <= '0;
      for (int i = 0; i < NR; i++) begin
        plane[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        for (int i = 0; i < NR; i++) begin
          if (cfg_index == fvc_pkg::CFG_IDX_W'(i)) begin
            plane[i] <= cfg_data;
          end
        end
      end
      if (s1_ready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        out_valid <= s2_valid && s2_emit;
      end
      if (s2_fire) begin
        all_out <= all_out_next;
        any_out <= any_out_next;
      end
    end
  end

  // Payload stages: no reset
  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_op     <= s_axis_tuser;
      s1_last   <= s_axis_tlast;
      for (int a = 0; a < 3; a++) begin
        s1_p[a] <= fvc_pkg::coord_t'(s_axis_tdata[a*CW +: CW]);
        s1_q[a] <= fvc_pkg::coord_t'(s_axis_tdata[(a+3)*CW +: CW]);
      end
      s1_radius <= s_axis_tdata[6*CW +: fvc_pkg::RADIUS_W];
    end
    if (s2_ready) begin
      s2_op     <= s1_op;
      s2_last   <= s1_last;
      s2_radius <= s1_radius;
    end
    if (out_ready) begin
      out_vis <= s2_vis;
    end
  end

`ifndef SYNTHESIS
  a_set_closes: assert property (@(posedge clk) disable iff (rst)
    (s2_fire && s2_op == fvc_pkg::OP_POINT && s2_last) |=>
      (all_out == '1 && any_out == '0))
    else $error("point set state not cleared after last point");

  a_all_within_any: assert property (@(posedge clk) disable iff (rst)
    (any_out != '0) |-> ((all_out & ~any_out) == '0))
    else $error("all-out bit set for a plane with no point outside");

  a_volume_keeps_set: assert property (@(posedge clk) disable iff (rst)
    (s2_fire && s2_op != fvc_pkg::OP_POINT) |=> ($stable(all_out) && $stable(any_out)))
    else $error("sphere or box item disturbed the open point set");

  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && s2_valid && out_valid))
    else $error("input stalled with a free pipeline stage");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Frustum classifier testbench
// Streams point sets, spheres and boxes into the classifier under several
// plane settings and random flow control on both sides, predicts each
// visibility code in the bench itself and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int     ONE_Q14      = 16384;
  localparam longint LIMIT_CYCLES = 400000;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     MAX_REPORTS  = 10;
  localparam int     RANDOM_BLOCK = 200;

  typedef enum {
    SHAPE_BOX,
    SHAPE_TILTED,
    SHAPE_EXTREME,
    SHAPE_SPARSE,
    SHAPE_RANDOM
  } frustum_shape_t;

  typedef logic [fvc_pkg::RADIUS_W-1:0] radius_t;
  typedef logic [fvc_pkg::PLANE_W-1:0]  plane_set_t [fvc_pkg::NUM_REGS];

  typedef struct {
    logic [1:0]      op;
    fvc_pkg::coord_t px, py, pz;
    fvc_pkg::coord_t qx, qy, qz;
    radius_t         radius;
    logic            is_last;
  } volume_item_t;

  logic                          clk;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [111:0]                  s_axis_tdata;
  logic                          s_axis_tlast;
  logic [1:0]                    s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [7:0]                    m_axis_tdata;
  logic                          cfg_we;
  logic [fvc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fvc_pkg::PLANE_W-1:0]   cfg_data;

  // Bench copy of the planes and the open point set
  logic [fvc_pkg::PLANE_W-1:0]   plane_q [fvc_pkg::NUM_REGS];
  logic [fvc_pkg::NUM_REGS-1:0]  set_all_out;
  logic [fvc_pkg::NUM_REGS-1:0]  set_any_out;
  logic [1:0]                    visibility_q [$];

  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_cycles;
  int     mismatches;
  int     coord_span;
  int     shape_counter;
  longint cycles;

  frustum_volume_classifier_3d dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint plane_normal(int i, int a);
    fvc_pkg::norm_t n;
    n = plane_q[i][16*a +: 16];
    return longint'(n);
  endfunction

  function automatic longint plane_offset(int i);
    fvc_pkg::coord_t o;
    o = plane_q[i][63:48];
    return longint'(o) <<< fvc_pkg::NORM_FRAC;
  endfunction

  function automatic longint plane_distance(int i, longint c[3]);
    return plane_normal(i, 0) * c[0] + plane_normal(i, 1) * c[1] +
           plane_normal(i, 2) * c[2] + plane_offset(i);
  endfunction

  function automatic bit predict_visibility(input volume_item_t it, output logic [1:0] vis);
    longint                       p [3];
    longint                       q [3];
    logic [fvc_pkg::NUM_REGS-1:0] outbits;
    longint                       rs, d, dmax, dmin, u, v;
    bit                           straddles;
    p[0] = it.px; p[1] = it.py; p[2] = it.pz;
    q[0] = it.qx; q[1] = it.qy; q[2] = it.qz;
    vis = fvc_pkg::VIS_INSIDE;
    straddles = 1'b0;
    case (it.op)
      fvc_pkg::OP_POINT: begin
        outbits = '0;
        for (int i = 0; i < fvc_pkg::PLANE_COUNT; i++)
          if (plane_distance(i, p) < 0) outbits[i] = 1'b1;
        set_all_out &= outbits;
        set_any_out |= outbits;
        if (!it.is_last) return 1'b0;
        if ((set_all_out & fvc_pkg::ACTIVE_MASK) != '0) vis = fvc_pkg::VIS_OUTSIDE;
        else if ((set_any_out & fvc_pkg::ACTIVE_MASK) != '0) vis = fvc_pkg::VIS_CROSS;
        set_all_out = '1;
        set_any_out = '0;
        return 1'b1;
      end
      fvc_pkg::OP_SPHERE: begin
        rs = longint'(it.radius) <<< fvc_pkg::NORM_FRAC;
        for (int i = 0; i < fvc_pkg::PLANE_COUNT; i++) begin
          d = plane_distance(i, p);
          if (d < -rs) begin
            vis = fvc_pkg::VIS_OUTSIDE;
            return 1'b1;
          end
          if (d < rs) straddles = 1'b1;
        end
        vis = straddles ? fvc_pkg::VIS_CROSS : fvc_pkg::VIS_INSIDE;
        return 1'b1;
      end
      fvc_pkg::OP_BOX: begin
        // Pick the far and near corner per plane, axis by axis
        for (int i = 0; i < fvc_pkg::PLANE_COUNT; i++) begin
          dmax = plane_offset(i);
          dmin = dmax;
          for (int a = 0; a < 3; a++) begin
            u = plane_normal(i, a) * p[a];
            v = plane_normal(i, a) * q[a];
            dmax += (u > v) ? u : v;
            dmin += (u < v) ? u : v;
          end
          if (dmax < 0) begin
            vis = fvc_pkg::VIS_OUTSIDE;
            return 1'b1;
          end
          if (dmin < 0) straddles = 1'b1;
        end
        vis = straddles ? fvc_pkg::VIS_CROSS : fvc_pkg::VIS_INSIDE;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int extreme_value();
    case ($urandom_range(3))
      0:       return 32767;
      1:       return -32768;
      2:       return 0;
      default: return ONE_Q14;
    endcase
  endfunction

  function automatic plane_set_t build_frustum(frustum_shape_t shape, int half);
    plane_set_t planes;
    int         n [3];
    int         off;
    for (int i = 0; i < fvc_pkg::NUM_REGS; i++) begin
      n = '{0, 0, 0};
      off = half;
      case (shape)
        SHAPE_BOX, SHAPE_SPARSE: begin
          n[i/2] = (i % 2 == 0) ? ONE_Q14 : -ONE_Q14;
        end
        SHAPE_TILTED: begin
          for (int a = 0; a < 3; a++) n[a] = int'($urandom_range(0, 8000)) - 4000;
          n[i/2] = int'($urandom_range(10000, ONE_Q14 - 1));
          if (i % 2 != 0) n[i/2] = -n[i/2];
          off = $urandom_range(0, half);
        end
        SHAPE_EXTREME: begin
          for (int a = 0; a < 3; a++) n[a] = extreme_value();
          off = extreme_value();
        end
        default: ;
      endcase
      planes[i] = {fvc_pkg::coord_t'(off), fvc_pkg::norm_t'(n[2]),
                   fvc_pkg::norm_t'(n[1]), fvc_pkg::norm_t'(n[0])};
      if (shape == SHAPE_RANDOM) planes[i] = {$urandom, $urandom};
      if (shape == SHAPE_SPARSE && $urandom_range(2) == 0) planes[i] = '0;
    end
    coord_span = (shape == SHAPE_RANDOM || shape == SHAPE_EXTREME) ? 32767 : 2 * half;
    return planes;
  endfunction

  function automatic fvc_pkg::coord_t rand_coord(int span);
    case ($urandom_range(15))
      0:       return fvc_pkg::coord_t'($urandom);
      1:       return $urandom_range(1) ? fvc_pkg::coord_t'(32767) : fvc_pkg::coord_t'(-32768);
      2, 3:    return fvc_pkg::coord_t'(int'($urandom_range(0, span)) - span / 2);
      default: return fvc_pkg::coord_t'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic fvc_pkg::coord_t nudge(fvc_pkg::coord_t base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return fvc_pkg::coord_t'(v);
  endfunction

  function automatic radius_t rand_radius();
    case ($urandom_range(7))
      0:       return '0;
      1:       return radius_t'($urandom);
      default: return radius_t'($urandom_range(0, coord_span / 2));
    endcase
  endfunction

  function automatic volume_item_t random_volume(logic [1:0] op, logic is_last);
    volume_item_t it;
    it.op      = op;
    it.px      = rand_coord(coord_span);
    it.py      = rand_coord(coord_span);
    it.pz      = rand_coord(coord_span);
    it.qx      = rand_coord(coord_span);
    it.qy      = rand_coord(coord_span);
    it.qz      = rand_coord(coord_span);
    it.radius  = rand_radius();
    it.is_last = is_last;
    return it;
  endfunction

  function automatic volume_item_t make_volume(logic [1:0] op, int px, int py, int pz,
                                               int qx, int qy, int qz, int r, bit is_last);
    volume_item_t it;
    it.op      = op;
    it.px      = fvc_pkg::coord_t'(px);
    it.py      = fvc_pkg::coord_t'(py);
    it.pz      = fvc_pkg::coord_t'(pz);
    it.qx      = fvc_pkg::coord_t'(qx);
    it.qy      = fvc_pkg::coord_t'(qy);
    it.qz      = fvc_pkg::coord_t'(qz);
    it.radius  = radius_t'(r);
    it.is_last = is_last;
    return it;
  endfunction

  // ---------------------------------------------------------------- bus tasks

  task automatic send_volume(input volume_item_t it);
    logic [1:0] vis;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it.radius, it.qz, it.qy, it.qx, it.pz, it.py, it.px};
    s_axis_tlast  <= it.is_last;
    s_axis_tuser  <= it.op;
    do @(posedge clk); while (!s_axis_tready);
    if (predict_visibility(it, vis)) visibility_q.push_back(vis);
  endtask

  // Hold until every expected result is in, then let the pipeline empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (visibility_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_planes(input plane_set_t planes);
    for (int i = 0; i < fvc_pkg::NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= fvc_pkg::CFG_IDX_W'(i);
      cfg_data  <= planes[i];
      @(posedge clk);
      plane_q[i] = planes[i];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic check_visibility(input logic [7:0] got);
    logic [7:0] want;
    if (visibility_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result: tdata 0x%02h with nothing expected", got);
      return;
    end
    want = {6'b0, visibility_q.pop_front()};
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("visibility mismatch: expected %0d, got tdata 0x%02h", want, got);
    end
  endtask

  // Result side: check each accepted item, then pick the next ready level
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) check_visibility(m_axis_tdata);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    send_idle_pct = 34;
    recv_idle_pct = 77;
    // Planes still at reset: all zero
    send_volume(make_volume(fvc_pkg::OP_POINT, 32767, -32768, 0, 0, 0, 0, 0, 1));
    send_volume(make_volume(fvc_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 32767, 0));
    send_volume(make_volume(fvc_pkg::OP_BOX, -32768, -32768, -32768,
                            32767, 32767, 32767, 0, 0));
    drain();
    program_planes(build_frustum(SHAPE_BOX, 1600));
    // Zero radius, on the right plane, just past it, biggest radius
    send_volume(make_volume(fvc_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_volume(make_volume(fvc_pkg::OP_SPHERE, 1600, 0, 0, 0, 0, 0, 0, 0));
    send_volume(make_volume(fvc_pkg::OP_SPHERE, 1601, 0, 0, 0, 0, 0, 0, 0));
    send_volume(make_volume(fvc_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 32767, 0));
    send_volume(make_volume(fvc_pkg::OP_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767, 1));
    // Boxes, corners in both orders
    send_volume(make_volume(fvc_pkg::OP_BOX, -100, -100, -100, 100, 100, 100, 0, 0));
    send_volume(make_volume(fvc_pkg::OP_BOX, 100, 100, 100, -100, -100, -100, 0, 0));
    send_volume(make_volume(fvc_pkg::OP_BOX, 1500, 0, 0, 1700, 10, 10, 0, 0));
    send_volume(make_volume(fvc_pkg::OP_BOX, 1700, 10, 10, 1500, 0, 0, 0, 0));
    send_volume(make_volume(fvc_pkg::OP_BOX, 2000, 0, 0, 3000, 0, 0, 0, 0));
    send_volume(make_volume(fvc_pkg::OP_BOX, 32767, -32768, 32767,
                            -32768, 32767, -32768, 0, 1));
    // Point set with spheres, boxes and an unused op in the middle
    send_volume(make_volume(fvc_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0));
    send_volume(make_volume(fvc_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 100, 0));
    send_volume(make_volume(fvc_pkg::OP_BOX, 5000, 0, 0, 6000, 0, 0, 0, 0));
    send_volume(make_volume(fvc_pkg::OP_POINT, 2000, 0, 0, 0, 0, 0, 0, 0));
    send_volume(make_volume(OP_UNUSED, 3000, 0, 0, 0, 0, 0, 0, 1));
    send_volume(make_volume(fvc_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 0, 1));
    // All points out of one plane, then out of opposite planes
    send_volume(make_volume(fvc_pkg::OP_POINT, 2000, 0, 0, 0, 0, 0, 0, 0));
    send_volume(make_volume(fvc_pkg::OP_POINT, 3000, 5, 5, 0, 0, 0, 0, 1));
    send_volume(make_volume(fvc_pkg::OP_POINT, 2000, 0, 0, 0, 0, 0, 0, 0));
    send_volume(make_volume(fvc_pkg::OP_POINT, -2000, 0, 0, 0, 0, 0, 0, 1));
    drain();
  endtask

  task automatic send_random_mix(input int items);
    int              count;
    int              len;
    int              spread;
    fvc_pkg::coord_t cx, cy, cz;
    volume_item_t    it;
    count = 0;
    while (count < items) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          // Clustered point set, now and then broken up by other volumes
          len = $urandom_range(1, 8);
          spread = $urandom_range(0, coord_span / 4);
          cx = rand_coord(coord_span);
          cy = rand_coord(coord_span);
          cz = rand_coord(coord_span);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(7) == 0) begin
              send_volume(random_volume($urandom_range(1) ? fvc_pkg::OP_SPHERE
                                                          : fvc_pkg::OP_BOX,
                                        1'($urandom_range(1))));
              count++;
            end
            it = random_volume(fvc_pkg::OP_POINT, k == len - 1);
            it.px = nudge(cx, spread);
            it.py = nudge(cy, spread);
            it.pz = nudge(cz, spread);
            send_volume(it);
            count++;
          end
        end
        6: begin
          send_volume(random_volume(fvc_pkg::OP_SPHERE, 1'($urandom_range(1))));
          count++;
        end
        7: begin
          send_volume(random_volume(fvc_pkg::OP_BOX, 1'($urandom_range(1))));
          count++;
        end
        8: begin
          spread = $urandom_range(0, coord_span / 4);
          it = random_volume(fvc_pkg::OP_BOX, 1'($urandom_range(1)));
          it.qx = nudge(it.px, spread);
          it.qy = nudge(it.py, spread);
          it.qz = nudge(it.pz, spread);
          send_volume(it);
          count++;
        end
        default: begin
          // Noise: unused op, or a stray point with a random last flag
          if ($urandom_range(1)) begin
            send_volume(random_volume(OP_UNUSED, 1'($urandom_range(1))));
          end else begin
            send_volume(random_volume(fvc_pkg::OP_POINT, 1'($urandom_range(1))));
            count++;
          end
        end
      endcase
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int blk = 0; blk < 3; blk++) begin
      drain();
      program_planes(build_frustum(frustum_shape_t'(shape_counter % 5),
                                   $urandom_range(256, 12000)));
      shape_counter++;
      send_random_mix(RANDOM_BLOCK);
    end
    drain();
  endtask

  // Stall the result side for a long stretch so the block backs up its input
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_planes(build_frustum(SHAPE_TILTED, 4000));
    hold_cycles = 300;
    for (int k = 0; k < 120; k++)
      send_volume(random_volume($urandom_range(1) ? fvc_pkg::OP_SPHERE : fvc_pkg::OP_BOX,
                                1'($urandom_range(1))));
    drain();
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = fvc_pkg::OP_POINT;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 0;
    mismatches    = 0;
    shape_counter = 0;
    coord_span    = 32767;
    for (int i = 0; i < fvc_pkg::NUM_REGS; i++) plane_q[i] = '0;
    set_all_out = '1;
    set_any_out = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_traffic(34, 77);
    test_random_traffic(77, 34);
    test_random_traffic(0, 0);
    test_output_stall();

    if (mismatches == 0 && visibility_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
